### hw/rtl/hte_pkg.sv
package hte_pkg;

  localparam int WIN_DEPTH = 9;
  localparam int FILL_W = $clog2(WIN_DEPTH + 1);
  localparam int LEN_W = 17;
  localparam int ENT_NUM = 6;

  localparam logic [FILL_W-1:0] OPEN_AVAIL = FILL_W'(8);
  localparam logic [FILL_W-1:0] CLOSE_AVAIL = FILL_W'(9);

  localparam logic [7:0] CH_LT = 8'h3C;
  localparam logic [7:0] CH_GT = 8'h3E;
  localparam logic [7:0] CH_AMP = 8'h26;
  localparam logic [7:0] CH_SP = 8'h20;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_LOW_A = 8'h61;
  localparam logic [7:0] CH_LOW_Z = 8'h7A;
  localparam logic [7:0] CASE_GAP = 8'h20;

  // Patterns are left aligned: the first character sits in the top byte.
  localparam logic [71:0] PAT_OPEN_SCRIPT = {"<script", 16'h0};
  localparam logic [71:0] PAT_OPEN_STYLE = {"<style", 24'h0};
  localparam logic [71:0] PAT_CLOSE_SCRIPT = {"</script", 8'h0};
  localparam logic [71:0] PAT_CLOSE_STYLE = {"</style", 16'h0};
  localparam logic [FILL_W-1:0] LEN_OPEN_SCRIPT = FILL_W'(7);
  localparam logic [FILL_W-1:0] LEN_OPEN_STYLE = FILL_W'(6);
  localparam logic [FILL_W-1:0] LEN_CLOSE_SCRIPT = FILL_W'(8);
  localparam logic [FILL_W-1:0] LEN_CLOSE_STYLE = FILL_W'(7);

  localparam logic [71:0] ENT_PAT [ENT_NUM] = '{
    {"&amp;", 32'h0}, {"&lt;", 40'h0}, {"&gt;", 40'h0},
    {"&quot;", 24'h0}, {"&nbsp;", 24'h0}, {"&#39;", 32'h0}
  };
  localparam logic [FILL_W-1:0] ENT_LEN [ENT_NUM] = '{
    FILL_W'(5), FILL_W'(4), FILL_W'(4), FILL_W'(6), FILL_W'(6), FILL_W'(5)
  };
  localparam logic [7:0] ENT_CHAR [ENT_NUM] = '{
    8'h26, 8'h3C, 8'h3E, 8'h22, 8'h20, 8'h27
  };

  typedef logic [WIN_DEPTH-1:0][7:0] win_t;

  typedef struct packed {
    logic       tag;
    logic       script;
    logic       style;
    logic       lws;
    logic [2:0] eskip;
  } flags_t;

  typedef struct packed {
    logic [7:0] text;
    logic       valid;
    logic       eot;
  } result_t;

  function automatic logic match_pat(input win_t win, input logic [71:0] pat,
                                     input logic [FILL_W-1:0] len, input logic nocase);
    logic       ok;
    logic [7:0] p;
    logic [7:0] w;
    ok = 1'b1;
    for (int k = 0; k < WIN_DEPTH; k++) begin
      p = pat[71-8*k -: 8];
      w = win[k];
      if (FILL_W'(k) < len) begin
        if (!(w == p || (nocase && p >= CH_LOW_A && p <= CH_LOW_Z && w == p - CASE_GAP))) begin
          ok = 1'b0;
        end
      end
    end
    return ok;
  endfunction

endpackage

### hw/rtl/hte_judge.sv
module hte_judge (
  input  hte_pkg::win_t                   win,
  input  logic [hte_pkg::FILL_W-1:0]      avail,
  input  hte_pkg::flags_t                 flags,
  input  logic [hte_pkg::LEN_W-1:0]       emitted,
  input  logic [hte_pkg::LEN_W-1:0]       max_len,
  output hte_pkg::flags_t                 flags_nxt,
  output logic                            emit,
  output logic [7:0]                      text_out
);
  import hte_pkg::*;

  logic [7:0] c;
  logic [7:0] c_ws;
  logic       room;
  logic [7:0] ent_ch;
  logic [2:0] ent_skip;

  assign c = win[0];
  assign c_ws = (c == CH_LF || c == CH_CR || c == CH_TAB) ? CH_SP : c;
  assign room = emitted < max_len;

  always_comb begin
    ent_ch = CH_AMP;
    ent_skip = 3'd0;
    for (int e = ENT_NUM - 1; e >= 0; e--) begin
      if (ENT_LEN[e] <= avail && match_pat(win, ENT_PAT[e], ENT_LEN[e], 1'b0)) begin
        ent_ch = ENT_CHAR[e];
        ent_skip = 3'(ENT_LEN[e] - FILL_W'(1));
      end
    end
  end

  always_comb begin
    flags_nxt = flags;
    emit = 1'b0;
    text_out = c_ws;
    if (flags.eskip != 3'd0) begin
      flags_nxt.eskip = flags.eskip - 3'd1;
    end else if (c == CH_LT) begin
      flags_nxt.tag = 1'b1;
      if (avail >= OPEN_AVAIL) begin
        if (match_pat(win, PAT_OPEN_SCRIPT, LEN_OPEN_SCRIPT, 1'b1)) flags_nxt.script = 1'b1;
        if (match_pat(win, PAT_OPEN_STYLE, LEN_OPEN_STYLE, 1'b1)) flags_nxt.style = 1'b1;
      end
      if (avail >= CLOSE_AVAIL) begin
        if (match_pat(win, PAT_CLOSE_SCRIPT, LEN_CLOSE_SCRIPT, 1'b1)) flags_nxt.script = 1'b0;
        if (match_pat(win, PAT_CLOSE_STYLE, LEN_CLOSE_STYLE, 1'b1)) flags_nxt.style = 1'b0;
      end
    end else if (c == CH_GT) begin
      flags_nxt.tag = 1'b0;
    end else if (!(flags.tag || flags.script || flags.style)) begin
      if (c == CH_AMP) begin
        text_out = ent_ch;
        flags_nxt.eskip = ent_skip;
        flags_nxt.lws = 1'b0;
        emit = room;
      end else if (!(c_ws == CH_SP && flags.lws)) begin
        flags_nxt.lws = (c_ws == CH_SP);
        emit = room;
      end
    end
  end

endmodule

### hw/rtl/hte_obuf.sv
module hte_obuf (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  hte_pkg::result_t wr_data,
  output logic             space,
  output logic             rd_valid,
  input  logic             rd_ready,
  output hte_pkg::result_t rd_data
);
  import hte_pkg::*;

  result_t    mem_r [2];
  logic       wr_ptr_r;
  logic       wr_ptr_nxt;
  logic       rd_ptr_r;
  logic       rd_ptr_nxt;
  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;
  logic       rd_en;

  assign space = cnt_r != 2'd2;
  assign rd_valid = cnt_r != 2'd0;
  assign rd_data = mem_r[rd_ptr_r];
  assign rd_en = rd_valid && rd_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ wr_en;
    rd_ptr_nxt = rd_ptr_r ^ rd_en;
    cnt_nxt = cnt_r + {1'b0, wr_en} - {1'b0, rd_en};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

### hw/rtl/hte_core.sv
module hte_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [7:0]                  in_byte,
  input  logic                        in_last,
  input  logic [hte_pkg::LEN_W-1:0]   max_len,
  input  logic                        space,
  output logic                        res_we,
  output hte_pkg::result_t            res
);
  import hte_pkg::*;

  win_t              win_r;
  win_t              win_nxt;
  logic [FILL_W-1:0] fill_r;
  logic [FILL_W-1:0] fill_nxt;
  flags_t            flags_r;
  flags_t            flags_nxt;
  logic [LEN_W-1:0]  emitted_r;
  logic [LEN_W-1:0]  emitted_nxt;
  logic              ended_r;
  logic              ended_nxt;
  logic              drain_r;
  logic              drain_nxt;
  logic              endp_r;
  logic              endp_nxt;

  win_t              win_app;
  logic [FILL_W-1:0] fill_app;
  win_t              jd_win;
  logic [FILL_W-1:0] jd_avail;
  flags_t            jd_flags;
  logic              jd_emit;
  logic [7:0]        jd_text;
  logic              jd_go;
  logic              accept;

  assign in_ready = !drain_r && space;
  assign accept = in_valid && in_ready;

  always_comb begin
    win_app = win_r;
    fill_app = fill_r;
    if (fill_r < FILL_W'(WIN_DEPTH)) begin
      win_app[fill_r] = in_byte;
      fill_app = fill_r + FILL_W'(1);
    end
    jd_win = drain_r ? win_r : win_app;
    jd_avail = drain_r ? fill_r : fill_app;
  end

  hte_judge u_judge (
    .win       (jd_win),
    .avail     (jd_avail),
    .flags     (flags_r),
    .emitted   (emitted_r),
    .max_len   (max_len),
    .flags_nxt (jd_flags),
    .emit      (jd_emit),
    .text_out  (jd_text)
  );

  always_comb begin
    win_nxt = win_r;
    fill_nxt = fill_r;
    flags_nxt = flags_r;
    emitted_nxt = emitted_r;
    ended_nxt = ended_r;
    drain_nxt = drain_r;
    endp_nxt = endp_r;
    res_we = 1'b0;
    res = '{text: CH_NUL, valid: 1'b0, eot: 1'b0};
    jd_go = 1'b0;

    if (drain_r) begin
      if (space) begin
        if (fill_r != '0) begin
          jd_go = 1'b1;
        end else begin
          drain_nxt = 1'b0;
          if (endp_r) begin
            res_we = 1'b1;
            res = '{text: CH_NUL, valid: 1'b0, eot: 1'b1};
            endp_nxt = 1'b0;
            flags_nxt = '0;
            emitted_nxt = '0;
            ended_nxt = 1'b0;
          end
        end
      end
    end else if (accept) begin
      if (!ended_r && in_byte == CH_NUL) begin
        ended_nxt = 1'b1;
        drain_nxt = 1'b1;
        endp_nxt = in_last;
      end else if (!ended_r) begin
        win_nxt = win_app;
        fill_nxt = fill_app;
        if (in_last) begin
          drain_nxt = 1'b1;
          endp_nxt = 1'b1;
        end else if (fill_app == FILL_W'(WIN_DEPTH)) begin
          jd_go = 1'b1;
        end
      end else if (in_last) begin
        drain_nxt = 1'b1;
        endp_nxt = 1'b1;
      end
    end

    if (jd_go) begin
      flags_nxt = jd_flags;
      for (int k = 0; k < WIN_DEPTH - 1; k++) begin
        win_nxt[k] = jd_win[k+1];
      end
      win_nxt[WIN_DEPTH-1] = jd_win[WIN_DEPTH-1];
      fill_nxt = jd_avail - FILL_W'(1);
      if (jd_emit) begin
        res_we = 1'b1;
        res = '{text: jd_text, valid: 1'b1, eot: 1'b0};
        emitted_nxt = emitted_r + LEN_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      flags_r <= '0;
      emitted_r <= '0;
      ended_r <= 1'b0;
      drain_r <= 1'b0;
      endp_r <= 1'b0;
    end else begin
      fill_r <= fill_nxt;
      flags_r <= flags_nxt;
      emitted_r <= emitted_nxt;
      ended_r <= ended_nxt;
      drain_r <= drain_nxt;
      endp_r <= endp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    win_r <= win_nxt;
  end

endmodule

### hw/rtl/html_text_extractor_unit.sv
// Streams HTML one byte per beat and returns the visible text one byte per beat. Bytes enter
// a nine-byte lookahead window, so a text byte comes out only once eight more bytes have
// arrived or the stream ends. The block takes a new beat in every cycle while the two-entry
// result buffer has room and it is not draining. A beat with tlast, or a zero byte, stops
// input while the single judge unit works through the window one byte per cycle as long as
// the buffer has room; the end marker (tuser clear, tlast set, zero data) is the last beat
// of every stream. The user must write max_output_length through the cfg port only while
// the block is idle; it does not enforce this. Values above LENGTH_LIMIT saturate to it.
module html_text_extractor_unit #(
  parameter int LENGTH_LIMIT = 65536
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [7:0]                  in_tdata,   // [7:0] in_byte
  input  logic                        in_tlast,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [7:0]                  out_tdata,  // [7:0] text_byte
  output logic [0:0]                  out_tuser,  // [0] byte_valid
  output logic                        out_tlast,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [hte_pkg::LEN_W-1:0]   cfg_data
);
  import hte_pkg::*;

  localparam int LEN_MAX = (1 << LEN_W) - 1;
  localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'((LENGTH_LIMIT > LEN_MAX) ? LEN_MAX
                                                                           : LENGTH_LIMIT);
  localparam logic [LEN_W-1:0] LEN_RST = (LEN_W'(4096) > LEN_CAP) ? LEN_CAP : LEN_W'(4096);

  logic [LEN_W-1:0] max_len_r;
  logic [LEN_W-1:0] max_len_nxt;
  logic             space;
  logic             res_we;
  result_t          res;
  result_t          out_res;

  assign cfg_ready = 1'b1;

  always_comb begin
    max_len_nxt = max_len_r;
    if (cfg_valid && cfg_ready) begin
      max_len_nxt = (cfg_data > LEN_CAP) ? LEN_CAP : cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= LEN_RST;
    end else begin
      max_len_r <= max_len_nxt;
    end
  end

  hte_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_byte  (in_tdata),
    .in_last  (in_tlast),
    .max_len  (max_len_r),
    .space    (space),
    .res_we   (res_we),
    .res      (res)
  );

  hte_obuf u_obuf (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (res_we),
    .wr_data  (res),
    .space    (space),
    .rd_valid (out_tvalid),
    .rd_ready (out_tready),
    .rd_data  (out_res)
  );

  assign out_tdata = out_res.text;
  assign out_tuser = out_res.valid;
  assign out_tlast = out_res.eot;

endmodule

### hw/rtl/hte_checker.sv
module hte_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic       in_tlast,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic [0:0] out_tuser,
  input logic       out_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))
    else $error("Stalled result beat changed.");

  a_end_marker: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> !out_tuser[0] && out_tdata == 8'h00)
    else $error("End marker carries a text byte.");

  a_text_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> !out_tlast && out_tdata != 8'h00)
    else $error("Text beat is zero or marked as end.");

  a_last_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> !in_tready)
    else $error("Input taken while the window drains.");

endmodule

bind html_text_extractor_unit hte_checker u_hte_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
